[rtl/core/dhfk_pkg.sv]
// ----------------------------------------------------------------------------
// dhfk_pkg
// shared types and constants for the dh chain forward kinematics block
// ----------------------------------------------------------------------------
package dhfk_pkg;

	localparam int CORDIC_STEPS = 18;
	localparam int STEP_BITS    = 5;
	localparam int ENTRY_BITS   = 24;
	localparam int LINK_BITS    = 20;

	typedef enum logic [1:0] {
		OP_IDENT = 2'd0,
		OP_LOAD  = 2'd1,
		OP_LINK  = 2'd2,
		OP_NONE  = 2'd3
	} op_t;

	typedef enum logic [1:0] {
		TW_ZERO = 2'd0,
		TW_PLUS = 2'd1,
		TW_MINUS = 2'd2,
		TW_PI   = 2'd3
	} twist_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_CORDIC,
		ST_LPOS,
		ST_MAC,
		ST_OUT
	} state_t;

	// arctangent of 2^-i in units of 2^-32 turn
	function automatic logic signed [31:0] atan_lut(input logic [STEP_BITS-1:0] i);
		logic signed [31:0] r;
		r = 32'sd0;
		unique case (i)
			5'd0:  r = 32'sd536870912;
			5'd1:  r = 32'sd316933406;
			5'd2:  r = 32'sd167458907;
			5'd3:  r = 32'sd85004756;
			5'd4:  r = 32'sd42667331;
			5'd5:  r = 32'sd21354465;
			5'd6:  r = 32'sd10679838;
			5'd7:  r = 32'sd5340245;
			5'd8:  r = 32'sd2670163;
			5'd9:  r = 32'sd1335087;
			5'd10: r = 32'sd667544;
			5'd11: r = 32'sd333772;
			5'd12: r = 32'sd166886;
			5'd13: r = 32'sd83443;
			5'd14: r = 32'sd41722;
			5'd15: r = 32'sd20861;
			5'd16: r = 32'sd10430;
			5'd17: r = 32'sd5215;
			default: r = 32'sd0;
		endcase
		return r;
	endfunction

endpackage

[rtl/core/dhfk_cordic.sv]
// ----------------------------------------------------------------------------
// dhfk_cordic
// iterative cordic, one micro-rotation a cycle, gives rounded cos and sin
// ----------------------------------------------------------------------------
module dhfk_cordic #(
	parameter int ANGLE_BITS = 16,
	parameter int ROT_BITS   = 16
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       start,
	input  logic signed [ANGLE_BITS-1:0] angle,
	output logic                       done,
	output logic signed [ROT_BITS-1:0] cos_val,
	output logic signed [ROT_BITS-1:0] sin_val
);
	localparam int FRAC = ROT_BITS - 2;
	localparam int SH   = 30 - FRAC;
	localparam logic signed [33:0] ONE  = 34'sd1 <<< FRAC;
	localparam logic signed [33:0] HALF = 34'sd1 <<< (SH - 1);

	logic signed [33:0] x_q, y_q, z_q;
	logic               flip_q, busy_q;
	logic [dhfk_pkg::STEP_BITS-1:0] i_q;

	logic signed [33:0] ph, xs, ys, xr, yr, xc, yc;
	logic signed [33:0] at;

	always_comb begin
		ph = 34'(signed'({angle, {(32-ANGLE_BITS){1'b0}}}));
		xs = x_q >>> i_q;
		ys = y_q >>> i_q;
		at = 34'(dhfk_pkg::atan_lut(i_q));
		xr = (x_q + HALF) >>> SH;
		yr = (y_q + HALF) >>> SH;
		xc = (xr > ONE) ? ONE : ((xr < -ONE) ? -ONE : xr);
		yc = (yr > ONE) ? ONE : ((yr < -ONE) ? -ONE : yr);
		if (flip_q) begin
			xc = -xc;
			yc = -yc;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			i_q    <= '0;
			done   <= 1'b0;
		end else begin
			done <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				i_q    <= '0;
			end else if (busy_q) begin
				if (i_q == dhfk_pkg::STEP_BITS'(dhfk_pkg::CORDIC_STEPS - 1)) begin
					busy_q <= 1'b0;
					done   <= 1'b1;
				end
				i_q <= i_q + 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			x_q <= 34'sd652032874;
			y_q <= '0;
			if (ph > (34'sd1 <<< 30)) begin
				z_q <= ph - (34'sd1 <<< 31);
				flip_q <= 1'b1;
			end else if (ph < -(34'sd1 <<< 30)) begin
				z_q <= ph + (34'sd1 <<< 31);
				flip_q <= 1'b1;
			end else begin
				z_q <= ph;
				flip_q <= 1'b0;
			end
		end else if (busy_q) begin
			if (z_q >= 0) begin
				x_q <= x_q - ys;
				y_q <= y_q + xs;
				z_q <= z_q - at;
			end else begin
				x_q <= x_q + ys;
				y_q <= y_q - xs;
				z_q <= z_q + at;
			end
		end
	end

	assign cos_val = ROT_BITS'(xc);
	assign sin_val = ROT_BITS'(yc);
endmodule

[rtl/core/dhfk_mac.sv]
// ----------------------------------------------------------------------------
// dhfk_mac
// shared multiply-accumulate unit, one product a cycle, registered product
// ----------------------------------------------------------------------------
module dhfk_mac #(
	parameter int A_BITS = 32,
	parameter int B_BITS = 24
) (
	input  logic                         clk,
	input  logic                         clr,
	input  logic                         en,
	input  logic signed [A_BITS-1:0]     a,
	input  logic signed [B_BITS-1:0]     b,
	output logic signed [A_BITS+B_BITS-1:0] acc
);
	logic signed [A_BITS+B_BITS-1:0] prod_s1;
	logic                            en_s1;

	always_ff @(posedge clk) begin
		prod_s1 <= a * b;
		en_s1   <= en;
		if (clr)
			acc <= '0;
		else if (en_s1)
			acc <= acc + prod_s1;
	end
endmodule

[rtl/core/dh_chain_forward_kinematics.sv]
// ----------------------------------------------------------------------------
// dh_chain_forward_kinematics
// accumulated homogeneous transform updated by dh links
// ----------------------------------------------------------------------------
// s_axis carries one command transaction: reset to identity, load one entry,
// right-multiply the held transform by one dh link matrix, or do nothing
// (operation 3). every accepted transaction gives exactly one m_axis
// transaction holding the full transform (nine rotation entries then three
// positions). after a reset or load is accepted, the sequencer passes through
// ST_OUT and m_axis_tvalid is registered from that state. a link runs the
// cordic (start, 18 micro-rotations, capture), then a*cos and a*sin on the
// shared multiplier, then the products (12 sums of 3 products through the
// same multiplier, each sum issued and then drained) and then ST_OUT.
// the block takes one transaction at a time: s_axis_tready is high only when
// idle and the result register is empty, so a stalled m_axis holds the result
// and blocks new input; the next command can be taken the cycle after the
// result transaction.
// arst_n sets the transform to identity with zero position and drops
// m_axis_tvalid.
// ----------------------------------------------------------------------------
module dh_chain_forward_kinematics #(
	parameter int ANGLE_BITS = 16,
	parameter int ROT_BITS   = 16,
	parameter int POS_BITS   = 24
) (
	input  logic clk,
	input  logic arst_n,
	input  logic s_axis_tvalid,
	output logic s_axis_tready,
	// operation, entry_index, entry_value, link_length, link_offset,
	// twist_code, joint_angle
	input  logic [((72+ANGLE_BITS+7)/8)*8-1:0] s_axis_tdata,
	output logic m_axis_tvalid,
	input  logic m_axis_tready,
	// rot_00..rot_22, pos_x, pos_y, pos_z
	output logic [((9*ROT_BITS+3*POS_BITS+7)/8)*8-1:0] m_axis_tdata
);
	localparam int FRAC = ROT_BITS - 2;
	localparam int AW   = (POS_BITS > 26) ? POS_BITS + 2 : 28;
	localparam int ACCW = AW + ROT_BITS + 2;
	localparam logic signed [ACCW-1:0] ONE  = ACCW'(1) <<< FRAC;
	localparam logic signed [ACCW-1:0] HALF = ACCW'(1) <<< (FRAC - 1);
	localparam logic signed [ACCW-1:0] PMAX = (ACCW'(1) <<< (POS_BITS-1)) - 1;
	localparam logic signed [ACCW-1:0] PMIN = -(ACCW'(1) <<< (POS_BITS-1));

	dhfk_pkg::state_t state_q, state_d;

	logic signed [ROT_BITS-1:0] rot_q [9];
	logic signed [ROT_BITS-1:0] nrot_q [9];
	logic signed [POS_BITS-1:0] pos_q [3];
	logic signed [POS_BITS-1:0] npos_q [3];
	logic signed [AW-1:0]       lp_q [3];
	logic signed [ROT_BITS-1:0] ct_q, st_q;

	logic [1:0]  op;
	logic [3:0]  idx;
	logic [3:0]  pidx;
	logic signed [23:0] val;
	logic signed [19:0] len_in, off_in;
	logic [1:0]  tw_q;
	logic signed [ANGLE_BITS-1:0] ang;

	logic [3:0] col_q;   // 0..2 rotation columns, 3 position
	logic [1:0] row_q, k_q;
	logic [1:0] cnt_q;   // drain count for mac pipe
	logic       phase_q;
	logic [3:0] rk_idx, rc_idx;

	logic       cs_start, cs_done;
	logic signed [ROT_BITS-1:0] cval, sval;

	logic       mac_clr, mac_en;
	logic signed [AW-1:0] mac_a;
	logic signed [ROT_BITS+1:0] mac_b;
	logic signed [ACCW-1:0] acc;

	logic signed [ROT_BITS+1:0] lmat;
	logic signed [ACCW-1:0] rnd, sat_r, sat_p, pnew;
	logic s_acc;

	assign op     = s_axis_tdata[1:0];
	assign idx    = s_axis_tdata[5:2];
	assign val    = s_axis_tdata[29:6];
	assign len_in = s_axis_tdata[49:30];
	assign off_in = s_axis_tdata[69:50];
	assign ang    = s_axis_tdata[72+ANGLE_BITS-1:72];
	assign pidx   = idx - 4'd9;
	assign s_acc  = s_axis_tvalid && s_axis_tready;
	assign s_axis_tready = (state_q == dhfk_pkg::ST_IDLE) && !m_axis_tvalid;

	// flat rotation index of (row, k) and (row, col)
	assign rk_idx = {2'b00, row_q} * 4'd3 + {2'b00, k_q};
	assign rc_idx = {2'b00, row_q} * 4'd3 + {2'b00, col_q[1:0]};

	// held link fields
	logic signed [19:0] off_q;
	logic signed [19:0] len_q;

	dhfk_cordic #(.ANGLE_BITS(ANGLE_BITS), .ROT_BITS(ROT_BITS)) u_cordic (
		.clk(clk), .arst_n(arst_n), .start(cs_start), .angle(ang),
		.done(cs_done), .cos_val(cval), .sin_val(sval)
	);

	dhfk_mac #(.A_BITS(AW), .B_BITS(ROT_BITS+2)) u_mac (
		.clk(clk), .clr(mac_clr), .en(mac_en), .a(mac_a), .b(mac_b), .acc(acc)
	);

	// entry of the link matrix at row k, column col
	always_comb begin
		logic signed [ROT_BITS+1:0] c2, s2;
		c2 = (ROT_BITS+2)'(ct_q);
		s2 = (ROT_BITS+2)'(st_q);
		lmat = '0;
		unique case ({k_q, col_q[1:0]})
			4'b0000: lmat = c2;
			4'b0001: lmat = (tw_q == dhfk_pkg::TW_ZERO) ? -s2 :
				((tw_q == dhfk_pkg::TW_PI) ? s2 : '0);
			4'b0010: lmat = (tw_q == dhfk_pkg::TW_PLUS) ? s2 :
				((tw_q == dhfk_pkg::TW_MINUS) ? -s2 : '0);
			4'b0100: lmat = s2;
			4'b0101: lmat = (tw_q == dhfk_pkg::TW_ZERO) ? c2 :
				((tw_q == dhfk_pkg::TW_PI) ? -c2 : '0);
			4'b0110: lmat = (tw_q == dhfk_pkg::TW_PLUS) ? -c2 :
				((tw_q == dhfk_pkg::TW_MINUS) ? c2 : '0);
			4'b1001: lmat = (tw_q == dhfk_pkg::TW_PLUS) ? (ROT_BITS+2)'(ONE) :
				((tw_q == dhfk_pkg::TW_MINUS) ? -(ROT_BITS+2)'(ONE) : '0);
			4'b1010: lmat = (tw_q == dhfk_pkg::TW_ZERO) ? (ROT_BITS+2)'(ONE) :
				((tw_q == dhfk_pkg::TW_PI) ? -(ROT_BITS+2)'(ONE) : '0);
			default: lmat = '0;
		endcase
	end

	// sequencer and multiplier operand select
	always_comb begin
		state_d  = state_q;
		cs_start = 1'b0;
		mac_clr  = 1'b0;
		mac_en   = 1'b0;
		mac_a    = '0;
		mac_b    = '0;
		unique case (state_q)
			dhfk_pkg::ST_IDLE: begin
				if (s_acc) begin
					if (dhfk_pkg::op_t'(op) == dhfk_pkg::OP_LINK) begin
						cs_start = 1'b1;
						state_d  = dhfk_pkg::ST_CORDIC;
					end else begin
						state_d = dhfk_pkg::ST_OUT;
					end
				end
			end
			dhfk_pkg::ST_CORDIC: begin
				mac_clr = 1'b1;
				if (cs_done)
					state_d = dhfk_pkg::ST_LPOS;
			end
			dhfk_pkg::ST_LPOS: begin
				// a*ct then a*st through the shared multiplier
				mac_clr = (cnt_q == 2'd0);
				mac_en  = !phase_q && (cnt_q == 2'd0);
				mac_a   = AW'(len_q);
				mac_b   = (ROT_BITS+2)'(k_q[0] ? st_q : ct_q);
				if (cnt_q == 2'd2 && k_q[0])
					state_d = dhfk_pkg::ST_MAC;
			end
			dhfk_pkg::ST_MAC: begin
				mac_clr = (k_q == 2'd0) && (cnt_q == 2'd0) && !phase_q;
				mac_en  = !phase_q;
				mac_a   = (col_q == 4'd3) ? lp_q[k_q] : AW'(rot_q[rk_idx]);
				mac_b   = (col_q == 4'd3) ? (ROT_BITS+2)'(rot_q[rk_idx]) : lmat;
				if (phase_q && cnt_q == 2'd2 && row_q == 2'd2 && col_q == 4'd3)
					state_d = dhfk_pkg::ST_OUT;
			end
			dhfk_pkg::ST_OUT: begin
				state_d = dhfk_pkg::ST_IDLE;
			end
			default: state_d = dhfk_pkg::ST_IDLE;
		endcase
	end

	// lp entries are wider than the rotation operand port; products with
	// position terms use the a operand instead
	assign rnd   = (acc + HALF) >>> FRAC;
	assign sat_r = (rnd > ONE) ? ONE : ((rnd < -ONE) ? -ONE : rnd);

	// position row: rounded R * lp added to the old position, saturated
	assign pnew  = rnd + ACCW'(pos_q[row_q]);
	assign sat_p = (pnew > PMAX) ? PMAX : ((pnew < PMIN) ? PMIN : pnew);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			state_q <= dhfk_pkg::ST_IDLE;
		else
			state_q <= state_d;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < 9; i++)
				rot_q[i] <= (i % 4 == 0) ? ROT_BITS'(ONE) : '0;
			for (int i = 0; i < 3; i++)
				pos_q[i] <= '0;
			m_axis_tvalid <= 1'b0;
			cnt_q   <= '0;
			phase_q <= 1'b0;
			k_q     <= '0;
			row_q   <= '0;
			col_q   <= '0;
		end else begin
			if (m_axis_tvalid && m_axis_tready)
				m_axis_tvalid <= 1'b0;
			if (state_q == dhfk_pkg::ST_OUT)
				m_axis_tvalid <= 1'b1;
			unique case (state_q)
				dhfk_pkg::ST_IDLE: begin
					cnt_q <= '0; phase_q <= 1'b0; k_q <= '0; row_q <= '0; col_q <= '0;
					if (s_acc) begin
						unique case (dhfk_pkg::op_t'(op))
							dhfk_pkg::OP_IDENT: begin
								for (int i = 0; i < 9; i++)
									rot_q[i] <= (i % 4 == 0) ? ROT_BITS'(ONE) : '0;
								for (int i = 0; i < 3; i++)
									pos_q[i] <= '0;
							end
							dhfk_pkg::OP_LOAD: begin
								if (idx < 4'd9)
									rot_q[idx] <= (ACCW'(val) > ONE) ? ROT_BITS'(ONE) :
										((ACCW'(val) < -ONE) ? ROT_BITS'(-ONE) :
										ROT_BITS'(val));
								else if (idx < 4'd12)
									pos_q[pidx[1:0]] <= (ACCW'(val) > PMAX) ?
										POS_BITS'(PMAX) : ((ACCW'(val) < PMIN) ?
										POS_BITS'(PMIN) : POS_BITS'(val));
							end
							default: ;
						endcase
					end
				end
				dhfk_pkg::ST_CORDIC: begin
					if (cs_done) begin
						ct_q <= cval;
						st_q <= sval;
					end
				end
				dhfk_pkg::ST_LPOS: begin
					// cnt 0 issue, 1 product, 2 accumulated
					if (cnt_q == 2'd2) begin
						lp_q[{1'b0, k_q[0]}] <= AW'(rnd);
						cnt_q <= '0;
						k_q   <= k_q[0] ? 2'd0 : 2'd1;
						if (k_q[0])
							lp_q[2] <= AW'(off_q);
					end else
						cnt_q <= cnt_q + 1'b1;
				end
				dhfk_pkg::ST_MAC: begin
					// three issues, then the drain counted by cnt_q
					if (!phase_q) begin
						if (k_q == 2'd2) begin
							phase_q <= 1'b1;
							cnt_q <= '0;
						end else
							k_q <= k_q + 1'b1;
					end else if (cnt_q == 2'd2) begin
						phase_q <= 1'b0;
						cnt_q <= '0;
						k_q <= '0;
						if (col_q == 4'd3) begin
							npos_q[row_q] <= POS_BITS'(sat_p);
							col_q <= '0;
							row_q <= row_q + 1'b1;
						end else begin
							nrot_q[rc_idx] <= ROT_BITS'(sat_r);
							col_q <= col_q + 1'b1;
						end
					end else
						cnt_q <= cnt_q + 1'b1;
				end
				dhfk_pkg::ST_OUT: ;
				default: ;
			endcase
			// last position row goes straight from the saturator
			if (state_q == dhfk_pkg::ST_MAC && state_d == dhfk_pkg::ST_OUT) begin
				for (int i = 0; i < 9; i++)
					rot_q[i] <= nrot_q[i];
				for (int i = 0; i < 2; i++)
					pos_q[i] <= npos_q[i];
				pos_q[2] <= POS_BITS'(sat_p);
			end
		end
	end

	// link fields held for the whole update
	always_ff @(posedge clk) begin
		if (s_acc) begin
			tw_q  <= s_axis_tdata[71:70];
			len_q <= len_in;
			off_q <= off_in;
		end
	end

	always_comb begin
		m_axis_tdata = '0;
		for (int i = 0; i < 9; i++)
			m_axis_tdata[i*ROT_BITS +: ROT_BITS] = rot_q[i];
		for (int i = 0; i < 3; i++)
			m_axis_tdata[9*ROT_BITS + i*POS_BITS +: POS_BITS] = pos_q[i];
	end

	a_busy_not_ready: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q != dhfk_pkg::ST_IDLE) |-> !s_axis_tready) else $error("ready while busy");
	a_one_result: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == dhfk_pkg::ST_OUT) |=> m_axis_tvalid) else $error("result lost");
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(m_axis_tvalid && !m_axis_tready) |=> $stable(m_axis_tdata)) else $error("unstable");
endmodule

[dv/tb_dh_chain_forward_kinematics.sv]
// ----------------------------------------------------------------------------
// tb_dh_chain_forward_kinematics
// self-checking bench for the dh chain forward kinematics block
// ----------------------------------------------------------------------------
// commands go in on s_axis, and each one gives exactly one transform on m_axis.
// a predictor in this bench keeps its own copy of the transform and works out
// the expected result for each command. directed tests come first, then random
// link chains mixed with loads, resets and noise. both sides idle at random,
// and the final part of the run has no idling at all.
// ----------------------------------------------------------------------------
module tb_dh_chain_forward_kinematics;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int ANGLE_BITS = 16;
	localparam int ROT_BITS   = 16;
	localparam int POS_BITS   = 24;
	localparam int ROT_FRAC   = ROT_BITS - 2;
	localparam int IN_W       = ((72 + ANGLE_BITS + 7) / 8) * 8;
	localparam int OUT_W      = ((9 * ROT_BITS + 3 * POS_BITS + 7) / 8) * 8;
	localparam longint ROT_ONE = 64'sd1 <<< ROT_FRAC;
	localparam longint POS_MAX = (64'sd1 <<< (POS_BITS - 1)) - 1;
	localparam longint POS_MIN = -(64'sd1 <<< (POS_BITS - 1));
	localparam int WATCHDOG   = 20000;

	logic clk;
	logic arst_n;
	logic s_axis_tvalid;
	logic s_axis_tready;
	logic [IN_W-1:0] s_axis_tdata;
	logic m_axis_tvalid;
	logic m_axis_tready;
	logic [OUT_W-1:0] m_axis_tdata;

	// one command as it travels on s_axis
	typedef struct {
		dhfk_pkg::op_t          opcode;
		logic [3:0]             idx;
		logic signed [23:0]     value;
		logic signed [19:0]     length;
		logic signed [19:0]     offset;
		dhfk_pkg::twist_t       twist;
		logic signed [ANGLE_BITS-1:0] theta;
	} command_t;

	// predicted transform: nine rotation entries then three positions
	typedef struct {
		longint rot [9];
		longint pos [3];
	} pose_t;

	pose_t pose_model;
	pose_t pose_queue [$];
	bit    failed;
	bit    idle_on;
	int    quiet_cycles = 0;

	dh_chain_forward_kinematics #(
		.ANGLE_BITS(ANGLE_BITS),
		.ROT_BITS(ROT_BITS),
		.POS_BITS(POS_BITS)
	) uut (
		.clk(clk),
		.arst_n(arst_n),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.s_axis_tdata(s_axis_tdata),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata(m_axis_tdata)
	);

	always begin
		clk = 1'b0;
		#5;
		clk = 1'b1;
		#5;
	end

	// arithmetic shift right that rounds toward minus infinity
	function automatic longint shr(input longint v, input int s);
		return v >>> s;
	endfunction

	function automatic longint sat(input longint v, input longint lo, input longint hi);
		return v < lo ? lo : (v > hi ? hi : v);
	endfunction

	function automatic void pose_identity();
		for (int i = 0; i < 9; i++) begin
			pose_model.rot[i] = (i % 4 == 0) ? ROT_ONE : 0;
		end
		for (int i = 0; i < 3; i++) begin
			pose_model.pos[i] = 0;
		end
	endfunction

	// cordic sine and cosine of theta, folded by half a turn into +-pi/2
	function automatic void theta_sincos(input logic signed [ANGLE_BITS-1:0] theta,
			output longint c, output longint s);
		logic [31:0] phase;
		longint z;
		longint x;
		longint y;
		longint nx;
		bit flip;
		phase = {theta, {(32 - ANGLE_BITS){1'b0}}};
		z = longint'($signed(phase));
		x = 652032874;
		y = 0;
		flip = 0;
		if (z > (64'sd1 <<< 30)) begin
			z -= 64'sd1 <<< 31;
			flip = 1;
		end else if (z < -(64'sd1 <<< 30)) begin
			z += 64'sd1 <<< 31;
			flip = 1;
		end
		for (int i = 0; i < dhfk_pkg::CORDIC_STEPS; i++) begin
			if (z >= 0) begin
				nx = x - shr(y, i);
				y = y + shr(x, i);
				z -= longint'(dhfk_pkg::atan_lut(i[dhfk_pkg::STEP_BITS-1:0]));
			end else begin
				nx = x + shr(y, i);
				y = y - shr(x, i);
				z += longint'(dhfk_pkg::atan_lut(i[dhfk_pkg::STEP_BITS-1:0]));
			end
			x = nx;
		end
		x = sat(shr(x + (64'sd1 <<< (29 - ROT_FRAC)), 30 - ROT_FRAC), -ROT_ONE, ROT_ONE);
		y = sat(shr(y + (64'sd1 <<< (29 - ROT_FRAC)), 30 - ROT_FRAC), -ROT_ONE, ROT_ONE);
		c = flip ? -x : x;
		s = flip ? -y : y;
	endfunction

	// right-multiply the held transform by one dh link matrix
	function automatic void chain_link(input command_t cmd);
		longint ct, st, ca, sa, acc;
		longint lm [9];
		longint lp [3];
		pose_t nxt;
		theta_sincos(cmd.theta, ct, st);
		ca = (cmd.twist == dhfk_pkg::TW_ZERO) ? 1 : (cmd.twist == dhfk_pkg::TW_PI ? -1 : 0);
		sa = (cmd.twist == dhfk_pkg::TW_PLUS) ? 1 : (cmd.twist == dhfk_pkg::TW_MINUS ? -1 : 0);
		lm[0] = ct;  lm[1] = -st * ca;      lm[2] = st * sa;
		lm[3] = st;  lm[4] = ct * ca;       lm[5] = -ct * sa;
		lm[6] = 0;   lm[7] = sa * ROT_ONE;  lm[8] = ca * ROT_ONE;
		lp[0] = shr(longint'(cmd.length) * ct + (ROT_ONE >>> 1), ROT_FRAC);
		lp[1] = shr(longint'(cmd.length) * st + (ROT_ONE >>> 1), ROT_FRAC);
		lp[2] = longint'(cmd.offset);
		for (int i = 0; i < 3; i++) begin
			for (int j = 0; j < 3; j++) begin
				acc = 0;
				for (int k = 0; k < 3; k++) begin
					acc += pose_model.rot[i*3+k] * lm[k*3+j];
				end
				nxt.rot[i*3+j] = sat(shr(acc + (ROT_ONE >>> 1), ROT_FRAC),
					-ROT_ONE, ROT_ONE);
			end
			acc = 0;
			for (int k = 0; k < 3; k++) begin
				acc += pose_model.rot[i*3+k] * lp[k];
			end
			nxt.pos[i] = sat(pose_model.pos[i] + shr(acc + (ROT_ONE >>> 1), ROT_FRAC),
				POS_MIN, POS_MAX);
		end
		pose_model = nxt;
	endfunction

	// update the predicted transform for one command and queue the result
	function automatic void predict_pose(input command_t cmd);
		case (cmd.opcode)
			dhfk_pkg::OP_IDENT: begin
				pose_identity();
			end
			dhfk_pkg::OP_LOAD: begin
				if (cmd.idx < 9) begin
					pose_model.rot[cmd.idx] = sat(longint'(cmd.value), -ROT_ONE, ROT_ONE);
				end else if (cmd.idx < 12) begin
					pose_model.pos[cmd.idx-9] = sat(longint'(cmd.value), POS_MIN, POS_MAX);
				end
			end
			dhfk_pkg::OP_LINK: begin
				chain_link(cmd);
			end
			default: begin
			end
		endcase
		pose_queue.push_back(pose_model);
	endfunction

	// send one command, waiting out the handshake; tvalid stays up between
	// back to back commands and drops only for an idle gap
	task automatic send_command(input command_t cmd);
		logic [IN_W-1:0] word;
		int gap;
		if (idle_on && $urandom_range(0, 3) == 0) begin
			gap = $urandom_range(1, 12);
			s_axis_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		word = '0;
		word[1:0]   = cmd.opcode;
		word[5:2]   = cmd.idx;
		word[29:6]  = cmd.value;
		word[49:30] = cmd.length;
		word[69:50] = cmd.offset;
		word[71:70] = cmd.twist;
		word[72 +: ANGLE_BITS] = cmd.theta;
		s_axis_tvalid <= 1'b1;
		s_axis_tdata  <= word;
		@(posedge clk);
		while (!s_axis_tready) @(posedge clk);
		predict_pose(cmd);
	endtask

	function automatic command_t random_link();
		command_t c;
		c.opcode = dhfk_pkg::OP_LINK;
		c.idx    = 4'($urandom);
		c.value  = 24'($urandom);
		// mostly realistic lengths, sometimes the full range
		if ($urandom_range(0, 3) == 0) begin
			c.length = 20'($urandom);
			c.offset = 20'($urandom);
		end else begin
			c.length = 20'($signed($urandom_range(0, 16000)) - 8000);
			c.offset = 20'($signed($urandom_range(0, 16000)) - 8000);
		end
		c.twist = dhfk_pkg::twist_t'($urandom_range(0, 3));
		c.theta = ANGLE_BITS'($urandom);
		return c;
	endfunction

	function automatic command_t make_load(input int index, input longint v);
		command_t c;
		c = random_link();
		c.opcode = dhfk_pkg::OP_LOAD;
		c.idx = 4'(index);
		c.value = 24'(v);
		return c;
	endfunction

	function automatic command_t make_link(input longint a, input longint d,
			input dhfk_pkg::twist_t tw, input longint th);
		command_t c;
		c = random_link();
		c.length = 20'(a);
		c.offset = 20'(d);
		c.twist = tw;
		c.theta = ANGLE_BITS'(th);
		return c;
	endfunction

	// resets, loads of some rotation entries and every position entry, out of range indexes, saturating values and a no-op
	task automatic test_loads();
		command_t c;
		c = random_link();
		c.opcode = dhfk_pkg::OP_IDENT;
		send_command(c);
		send_command(make_load(0, 24'sh7fffff));
		send_command(make_load(4, -24'sh800000));
		send_command(make_load(8, -16384));
		send_command(make_load(9, 24'sh7fffff));
		send_command(make_load(10, -24'sh800000));
		send_command(make_load(11, 1234));
		send_command(make_load(12, 5));
		send_command(make_load(15, -5));
		c = random_link();
		c.opcode = dhfk_pkg::OP_NONE;
		send_command(c);
		c.opcode = dhfk_pkg::OP_IDENT;
		send_command(c);
	endtask

	// every twist, angle extremes, field extremes and a saturating position
	task automatic test_links();
		send_command(make_link(2560, 0, dhfk_pkg::TW_ZERO, 0));
		send_command(make_link(-524288, 524287, dhfk_pkg::TW_PLUS, 16384));
		send_command(make_link(524287, -524288, dhfk_pkg::TW_MINUS, -32768));
		send_command(make_link(100, 200, dhfk_pkg::TW_PI, 32767));
		send_command(make_link(-1, 1, dhfk_pkg::TW_ZERO, -16384));
		send_command(make_load(9, 24'sh7ff000));
		send_command(make_link(524287, 524287, dhfk_pkg::TW_ZERO, 0));
		send_command(make_load(9, -24'sh7ff000));
		send_command(make_link(-524288, 0, dhfk_pkg::TW_ZERO, 0));
		send_command(make_link(0, 0, dhfk_pkg::TW_PLUS, 12345));
	endtask

	// random chains: links mixed with resets, loads and no-op commands
	task automatic test_random_chains(input int total);
		command_t c;
		int sent;
		sent = 0;
		while (sent < total) begin
			case ($urandom_range(0, 9))
				0: begin
					c = random_link();
					c.opcode = dhfk_pkg::OP_IDENT;
				end
				1: c = make_load($urandom_range(0, 15), longint'($signed(24'($urandom))));
				2: c = make_load($urandom_range(0, 8), $urandom_range(0, 32768) - 16384);
				3: begin
					c = random_link();
					c.opcode = dhfk_pkg::OP_NONE;
				end
				default: c = random_link();
			endcase
			send_command(c);
			sent++;
		end
	endtask

	task automatic wait_drained();
		int n;
		n = 0;
		s_axis_tvalid <= 1'b0;
		while (pose_queue.size() != 0 && n < 100000) begin
			@(posedge clk);
			n++;
		end
		repeat (80) @(posedge clk);
	endtask

	// result checker: unpack each transaction and compare with the oldest prediction
	always @(posedge clk) begin
		pose_t want;
		logic [ROT_BITS-1:0] got_r;
		logic [POS_BITS-1:0] got_p;
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			if (pose_queue.size() == 0) begin
				$display("%0t: unexpected result transaction %h", $time, m_axis_tdata);
				failed = 1;
			end else begin
				want = pose_queue.pop_front();
				for (int i = 0; i < 9; i++) begin
					got_r = m_axis_tdata[i*ROT_BITS +: ROT_BITS];
					if (got_r !== ROT_BITS'(want.rot[i])) begin
						$display("%0t: rot %0d expected %0d actual %0d", $time, i,
							want.rot[i], $signed(got_r));
						failed = 1;
					end
				end
				for (int i = 0; i < 3; i++) begin
					got_p = m_axis_tdata[9*ROT_BITS + i*POS_BITS +: POS_BITS];
					if (got_p !== POS_BITS'(want.pos[i])) begin
						$display("%0t: pos %0d expected %0d actual %0d", $time, i,
							want.pos[i], $signed(got_p));
						failed = 1;
					end
				end
			end
		end
	end

	// receiver stalls in random bursts while idling is on
	always @(posedge clk) begin
		int hold;
		if (!arst_n) begin
			m_axis_tready <= 1'b1;
			hold = 0;
		end else if (hold > 0) begin
			hold--;
			if (hold == 0) m_axis_tready <= 1'b1;
		end else if (idle_on && $urandom_range(0, 7) == 0) begin
			hold = $urandom_range(1, 12);
			m_axis_tready <= 1'b0;
		end else begin
			m_axis_tready <= 1'b1;
		end
	end

	// watchdog on cycles with no transaction on either side
	always @(posedge clk) begin
		if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
			quiet_cycles <= 0;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
		if (quiet_cycles >= WATCHDOG) begin
			$display("Mismatches found");
			$finish;
		end
	end

	initial begin
		failed = 0;
		idle_on = 1;
		arst_n = 1'b0;
		s_axis_tvalid = 1'b0;
		s_axis_tdata = '0;
		pose_identity();
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_loads();
		test_links();
		test_random_chains(350);
		idle_on = 0;
		test_random_chains(80);
		wait_drained();
		if (!failed && pose_queue.size() == 0) begin
			$display("No mismatches found");
		end else begin
			$display("Mismatches found");
		end
		$finish;
	end

endmodule

[sim.f]
rtl/core/dhfk_pkg.sv
rtl/core/dhfk_cordic.sv
rtl/core/dhfk_mac.sv
rtl/core/dh_chain_forward_kinematics.sv
dv/tb_dh_chain_forward_kinematics.sv
